@@ rtl/core/hhsd_pkg.sv @@
// Package for the header-hunting deframer: register indexes, field widths,
// the tracker state type and the structs passed between the modules.
// No dependencies.
package hhsd_pkg;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 6;
   localparam int FLEN_W   = 7;
   localparam int SKIP_W   = 16;
   localparam int SUM_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_LIMIT   = 2'd2;

   localparam int MIN_FRAME = 3;

   typedef enum logic {
      ST_HUNT,
      ST_FRAME
   } hhsd_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [FLEN_W-1:0] frame_length;
      logic [SKIP_W-1:0] skip_limit;
   } hhsd_cfg_type;

   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] frame_byte;
      logic [POS_W-1:0]  position;
      logic              last_of_frame;
      logic              checksum_ok;
      logic              header_forced;
   } hhsd_result_type;

endpackage

@@ rtl/core/hhsd_tracker.sv @@
// Frame tracker of the deframer: header hunt, byte position, running sum and
// trailing-word check, one byte per step.
// Depends on hhsd_pkg.
module hhsd_tracker import hhsd_pkg::*; #(
   parameter int MAX_FRAME = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  hhsd_cfg_type      cfg,
   output hhsd_result_type   res
);

   localparam int IDX_W = $clog2(MAX_FRAME);
   localparam int LEN_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = (LEN_W > FLEN_W) ? LEN_W : FLEN_W;

   hhsd_state_type    state_ff, state_in;
   logic [SKIP_W-1:0] skip_count_ff, skip_count_in;
   logic [IDX_W-1:0]  byte_index_ff, byte_index_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0] checksum_high_ff, checksum_high_in;
   logic              forced_flag_ff, forced_flag_in;

   logic [SKIP_W:0]   count;
   logic              hdr_hit;
   logic              limit_hit;
   logic              opens;
   logic [CMP_W-1:0]  flen;
   logic [CMP_W-1:0]  len;
   logic [IDX_W-1:0]  idx;
   logic [SUM_W-1:0]  sum;
   logic [BYTE_W-1:0] chigh;
   logic              forced;
   logic              is_last;
   logic              is_high;

   // Hunt decision and the view of the frame state that this byte sees.
   always_comb begin
      count     = {1'b0, skip_count_ff} + 1'b1;
      hdr_hit   = (rx_byte == cfg.header_byte);
      limit_hit = (count >= {1'b0, cfg.skip_limit});
      opens     = hdr_hit || limit_hit;

      flen = CMP_W'(cfg.frame_length);
      if (flen < CMP_W'(MIN_FRAME)) begin
         len = CMP_W'(MIN_FRAME);
      end else if (flen > CMP_W'(MAX_FRAME)) begin
         len = CMP_W'(MAX_FRAME);
      end else begin
         len = flen;
      end

      if (state_ff == ST_HUNT) begin
         idx    = '0;
         sum    = '0;
         chigh  = '0;
         forced = !hdr_hit;
      end else begin
         idx    = byte_index_ff;
         sum    = running_sum_ff;
         chigh  = checksum_high_ff;
         forced = forced_flag_ff;
      end

      is_last = (CMP_W'(idx) + 1'b1) >= len;
      is_high = (CMP_W'(idx) + 2'd2) == len;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (step) begin
         case (state_ff)
            ST_HUNT: begin
               if (opens && !is_last) begin
                  state_in = ST_FRAME;
               end
            end
            ST_FRAME: begin
               if (is_last) begin
                  state_in = ST_HUNT;
               end
            end
            default: state_in = ST_HUNT;
         endcase
      end
   end

   // Datapath state and the result of this step.
   always_comb begin
      skip_count_in    = skip_count_ff;
      byte_index_in    = byte_index_ff;
      running_sum_in   = running_sum_ff;
      checksum_high_in = checksum_high_ff;
      forced_flag_in   = forced_flag_ff;

      res.emit          = (state_ff == ST_FRAME) || opens;
      res.frame_byte    = rx_byte;
      res.position      = POS_W'(idx);
      res.last_of_frame = is_last;
      res.checksum_ok   = is_last && ({chigh, rx_byte} == sum);
      res.header_forced = forced;

      if (step) begin
         if (!res.emit) begin
            skip_count_in = count[SKIP_W-1:0];
         end else begin
            forced_flag_in = forced;
            if (is_last) begin
               skip_count_in    = '0;
               byte_index_in    = '0;
               running_sum_in   = '0;
               checksum_high_in = '0;
            end else begin
               skip_count_in    = '0;
               byte_index_in    = idx + 1'b1;
               running_sum_in   = is_high ? sum : sum + SUM_W'(rx_byte);
               checksum_high_in = is_high ? rx_byte : chigh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_HUNT;
         skip_count_ff    <= '0;
         byte_index_ff    <= '0;
         running_sum_ff   <= '0;
         checksum_high_ff <= '0;
         forced_flag_ff   <= 1'b0;
      end else begin
         state_ff         <= state_in;
         skip_count_ff    <= skip_count_in;
         byte_index_ff    <= byte_index_in;
         running_sum_ff   <= running_sum_in;
         checksum_high_ff <= checksum_high_in;
         forced_flag_ff   <= forced_flag_in;
      end
   end

   // The last byte of a frame always sends the tracker back to hunting.
   a_last_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (step && res.emit && res.last_of_frame) |=> (state_ff == ST_HUNT))
      else $error("tracker did not return to hunting after the last byte");

   // A pass verdict can only appear on the last byte.
   a_ok_only_last: assert property (@(posedge clock) disable iff (reset)
      (res.emit && res.checksum_ok) |-> res.last_of_frame)
      else $error("checksum pass reported before the last byte");

   // A skipped byte advances the skip count by exactly one.
   a_skip_counts: assert property (@(posedge clock) disable iff (reset)
      (step && state_ff == ST_HUNT && !res.emit) |=>
      (skip_count_ff == $past(skip_count_ff) + 1'b1))
      else $error("skip count did not advance on a skipped byte");

   // A frame opened on a header match is never marked as forced.
   a_match_not_forced: assert property (@(posedge clock) disable iff (reset)
      (step && state_ff == ST_HUNT && hdr_hit) |-> (res.emit && !res.header_forced))
      else $error("header match opened a frame marked as forced");

endmodule

@@ rtl/core/header_hunt_sum16_deframer.sv @@
// Header-hunting frame receiver with a 16-bit additive checksum.
// Received bytes enter on the req_ channel (req_valid, req_stall, req_rx_byte).
// While hunting, bytes that do not match the header byte are dropped and
// counted; a match, or reaching the skip limit, opens a frame of the
// configured length. Every frame byte leaves on the rsp_ channel with its
// position, a last-byte flag, the checksum verdict (on the last byte only)
// and a flag set when the skip limit rather than a match opened the frame.
// Registers are written through csr_wr_en, csr_index and csr_wdata; the user
// must write them only while the block is idle, which the block does not enforce.
// A frame byte accepted on req_ is held in the input register, passes the
// tracker and is presented on rsp_ from the output register.
// Throughput: one byte per cycle while the receiver does not stall, with the
// tracker stepping between the input register and the output register.
// When the receiver stalls, the result stays in the output register and one
// more byte may wait in the input register before req_stall is raised.
// Reset is synchronous: both channels empty, registers at their defaults
// (header 0, frame length 31, skip limit 1024) and the tracker hunting.
// Depends on hhsd_pkg and hhsd_tracker.
module header_hunt_sum16_deframer import hhsd_pkg::*; #(
   parameter int MAX_FRAME = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_frame_byte,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_last_of_frame,
   output logic                  rsp_checksum_ok,
   output logic                  rsp_header_forced
);

   hhsd_cfg_type      cfg_ff, cfg_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_valid_ff, out_valid_in;
   hhsd_result_type   out_ff, out_in;
   hhsd_result_type   res;
   logic              advance;
   logic              step;
   logic              req_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_BYTE:  cfg_in.header_byte  = csr_wdata[BYTE_W-1:0];
            CSR_FRAME_LENGTH: cfg_in.frame_length = csr_wdata[FLEN_W-1:0];
            CSR_SKIP_LIMIT:   cfg_in.skip_limit   = csr_wdata[SKIP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // The tracker steps when the input register holds a byte and the output register is empty or being emptied.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in = res.emit;
         out_in       = res;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   hhsd_tracker #(
      .MAX_FRAME (MAX_FRAME)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte  <= 8'd0;
         cfg_ff.frame_length <= 7'd31;
         cfg_ff.skip_limit   <= 16'd1024;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_byte    = out_ff.frame_byte;
   assign rsp_position      = out_ff.position;
   assign rsp_last_of_frame = out_ff.last_of_frame;
   assign rsp_checksum_ok   = out_ff.checksum_ok;
   assign rsp_header_forced = out_ff.header_forced;

endmodule
